[rtl/obnf_pkg.sv]
// shared constants, request codes, payload and control types for the walkability map
package obnf_pkg;

    localparam int CELLS_X     = 256;
    localparam int CELLS_Y     = 256;
    localparam int MAX_RADIUS  = 255;
    localparam int TOTAL_CELLS = CELLS_X * CELLS_Y;

    localparam int XW        = (CELLS_X > 1) ? $clog2(CELLS_X) : 1;
    localparam int YW        = (CELLS_Y > 1) ? $clog2(CELLS_Y) : 1;
    localparam int RW        = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
    localparam int CNTW      = $clog2(TOTAL_CELLS + 1);
    localparam int SW        = 18;
    localparam int CHUNK_W   = (CELLS_X < 32) ? CELLS_X : 32;
    localparam int NCHUNK    = (CELLS_X + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W     = NCHUNK * CHUNK_W;
    localparam int CHW       = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int CIW       = (CHUNK_W > 1) ? $clog2(CHUNK_W) : 1;
    localparam int REV_W     = 32;
    localparam int CNT_OUT_W = 17;

    typedef enum logic [2:0] {
        REQ_READ    = 3'd0,
        REQ_WRITE   = 3'd1,
        REQ_SET_ALL = 3'd2,
        REQ_SEARCH  = 3'd3,
        REQ_COUNT   = 3'd4
    } t_req;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [15:0] cell_x;
        logic signed [15:0] cell_y;
        logic               walkable_value;
        logic [7:0]         max_radius;
    } t_in;

    typedef struct packed {
        logic                 ok;
        logic [7:0]           found_x;
        logic [7:0]           found_y;
        logic [CNT_OUT_W-1:0] walkable_count;
        logic [REV_W-1:0]     revision;
    } t_out;

    typedef struct packed {
        logic load;
        logic disp_miss;
        logic rd_cell;
        logic upd_cell;
        logic set_all;
        logic row;
        logic adv;
        logic scan;
        logic miss;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [2:0] req;
        logic       cell_in_grid;
        logic       row_skip;
        logic       ring_last;
        logic       scan_hit;
        logic       scan_more;
        logic       out_free;
    } t_sts;

endpackage

[rtl/obnf_ctrl.sv]
// request sequencer for the walkability map
module obnf_ctrl
    import obnf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DISP    = 7'b0000010,
        S_CELL_RD = 7'b0000100,
        S_CELL    = 7'b0001000,
        S_ROW     = 7'b0010000,
        S_SCAN    = 7'b0100000,
        S_DONE    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                priority if (i_sts.req == REQ_READ || i_sts.req == REQ_WRITE) begin
                    if (i_sts.cell_in_grid) begin
                        n_state = S_CELL_RD;
                    end else begin
                        o_cmd.disp_miss = (i_sts.req == REQ_READ);
                        n_state         = S_DONE;
                    end
                end else if (i_sts.req == REQ_SET_ALL) begin
                    o_cmd.set_all = 1'b1;
                    n_state       = S_DONE;
                end else if (i_sts.req == REQ_SEARCH) begin
                    n_state = S_ROW;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CELL_RD: begin
                o_cmd.rd_cell = 1'b1;
                n_state       = S_CELL;
            end
            S_CELL: begin
                o_cmd.upd_cell = 1'b1;
                n_state        = S_DONE;
            end
            S_ROW: begin
                o_cmd.row = 1'b1;
                priority if (!i_sts.row_skip) begin
                    n_state = S_SCAN;
                end else if (i_sts.ring_last) begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.adv = 1'b1;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                priority if (i_sts.scan_hit) begin
                    n_state = S_DONE;
                end else if (i_sts.scan_more) begin
                    n_state = S_SCAN;
                end else if (i_sts.ring_last) begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = S_ROW;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/obnf_dp.sv]
// map memory, revision and count registers, ring search datapath and result register
module obnf_dp
    import obnf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    input  t_in  i_in_data,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_ready
);

    function automatic logic in_rng(input logic signed [SW-1:0] v, input int lim);
        return !v[SW-1] && (v < $signed(SW'(lim)));
    endfunction

    function automatic logic [REV_W-1:0] rev_inc(input logic [REV_W-1:0] v);
        logic [REV_W-1:0] s;
        s = v + REV_W'(1);
        return (s == '0) ? REV_W'(1) : s;
    endfunction

    logic [CELLS_X-1:0] r_mem [CELLS_Y];
    logic [CELLS_X-1:0] r_rdata;
    logic               r_rvld;
    logic [CELLS_Y-1:0] r_row_vld;
    logic               r_base;

    logic [2:0]         r_req;
    logic signed [15:0] r_cx;
    logic signed [15:0] r_cy;
    logic               r_val;
    logic [RW-1:0]      r_rmax;
    logic [RW-1:0]      r_r;
    logic signed [RW:0] r_dy;
    logic [CHW-1:0]     r_chunk;

    logic [REV_W-1:0]   r_rev;
    logic [CNTW-1:0]    r_cnt;
    logic               r_ok;
    logic [7:0]         r_fx;
    logic [7:0]         r_fy;
    t_out               r_out;
    logic               r_out_vld;

    logic [CELLS_X-1:0] row_data;
    logic [CELLS_X-1:0] wr_row;
    logic [PAD_W-1:0]   row_pad;
    logic [CHUNK_W-1:0] chunk_bits;
    logic [XW-1:0]      cx_i;
    logic [YW-1:0]      cy_i;
    logic               cell_bit;
    logic               cell_chg;
    logic               rd_en;
    logic [YW-1:0]      rd_addr;
    logic [RW-1:0]      rad_inc;
    logic signed [RW:0] dy_end;
    logic               edge_row;
    logic signed [SW-1:0] y_s;
    logic signed [SW-1:0] lo_s;
    logic signed [SW-1:0] hi_s;
    logic [XW-1:0]      lo_x;
    logic [XW-1:0]      hi_x;
    logic [CHW-1:0]     chunk_lo;
    logic [CHW-1:0]     chunk_hi;
    logic signed [SW-1:0] chunk_base;
    logic signed [SW-1:0] pos;
    logic               e_hit;
    logic [CIW-1:0]     e_idx;
    logic               l_ok;
    logic               rt_ok;
    logic               hit;
    logic signed [SW-1:0] hit_x;
    logic [RW-1:0]      rmax_in;

    assign cx_i     = XW'(r_cx);
    assign cy_i     = YW'(r_cy);
    assign row_data = r_rvld ? r_rdata : {CELLS_X{r_base}};
    assign row_pad  = PAD_W'(row_data);
    assign cell_bit = row_data[cx_i];
    assign cell_chg = (r_req == REQ_WRITE) && (cell_bit != r_val);
    assign rad_inc  = r_r + RW'(1);
    assign dy_end   = $signed({1'b0, r_r});
    assign edge_row = (r_dy == dy_end) || (r_dy == -dy_end);
    assign y_s      = SW'(r_cy) + SW'(r_dy);
    assign lo_s     = SW'(r_cx) - $signed(SW'({1'b0, r_r}));
    assign hi_s     = SW'(r_cx) + $signed(SW'({1'b0, r_r}));
    assign lo_x     = lo_s[SW-1] ? '0 : XW'(lo_s);
    assign hi_x     = (hi_s >= $signed(SW'(CELLS_X))) ? XW'(CELLS_X - 1) : XW'(hi_s);
    assign chunk_lo = CHW'(lo_x / CHUNK_W);
    assign chunk_hi = CHW'(hi_x / CHUNK_W);
    assign chunk_base = $signed(SW'(r_chunk * CHUNK_W));
    assign chunk_bits = row_pad[r_chunk * CHUNK_W +: CHUNK_W];
    assign rd_en    = i_cmd.rd_cell || i_cmd.row;
    assign rd_addr  = i_cmd.row ? YW'(y_s) : cy_i;
    assign rmax_in  = (i_in_data.max_radius > 13'(MAX_RADIUS)) ? RW'(MAX_RADIUS)
                                                              : RW'(i_in_data.max_radius);

    always_comb begin
        wr_row        = row_data;
        wr_row[cx_i]  = r_val;
    end

    // first walkable cell of the current chunk within the ring's span
    always_comb begin
        e_hit = 1'b0;
        e_idx = '0;
        pos   = '0;
        for (int p = CHUNK_W - 1; p >= 0; p--) begin
            pos = chunk_base + SW'(p);
            if (chunk_bits[p] && pos >= lo_s && pos <= hi_s) begin
                e_hit = 1'b1;
                e_idx = CIW'(p);
            end
        end
    end

    assign l_ok  = in_rng(lo_s, CELLS_X) && row_data[XW'(lo_s)];
    assign rt_ok = in_rng(hi_s, CELLS_X) && row_data[XW'(hi_s)];
    assign hit   = edge_row ? e_hit : (l_ok || rt_ok);

    always_comb begin
        if (edge_row) begin
            hit_x = chunk_base + SW'(e_idx);
        end else if (l_ok) begin
            hit_x = lo_s;
        end else begin
            hit_x = hi_s;
        end
    end

    always_comb begin
        o_sts.req          = r_req;
        o_sts.cell_in_grid = in_rng(SW'(r_cx), CELLS_X) && in_rng(SW'(r_cy), CELLS_Y);
        o_sts.row_skip     = !in_rng(y_s, CELLS_Y) ||
                             (edge_row ? (hi_s < 0 || lo_s >= $signed(SW'(CELLS_X)))
                                       : (!in_rng(lo_s, CELLS_X) && !in_rng(hi_s, CELLS_X)));
        o_sts.ring_last    = (r_dy == dy_end) && (r_r == r_rmax);
        o_sts.scan_hit     = hit;
        o_sts.scan_more    = edge_row && !e_hit && (r_chunk != chunk_hi);
        o_sts.out_free     = !r_out_vld || i_out_ready;
    end

    // map memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_cell && cell_chg) begin
            r_mem[cy_i] <= wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
            r_rvld  <= r_row_vld[rd_addr];
        end
    end

    // map state, revision and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_base    <= 1'b1;
            r_rev     <= '0;
            r_cnt     <= CNTW'(TOTAL_CELLS);
        end else if (i_cmd.set_all) begin
            r_row_vld <= '0;
            r_base    <= r_val;
            r_rev     <= rev_inc(r_rev);
            r_cnt     <= r_val ? CNTW'(TOTAL_CELLS) : '0;
        end else if (i_cmd.upd_cell && cell_chg) begin
            r_row_vld[cy_i] <= 1'b1;
            r_rev           <= rev_inc(r_rev);
            r_cnt           <= r_val ? r_cnt + CNTW'(1) : r_cnt - CNTW'(1);
        end
    end

    // request fields and search position
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_in_data.req_type;
            r_cx   <= i_in_data.cell_x;
            r_cy   <= i_in_data.cell_y;
            r_val  <= i_in_data.walkable_value;
            r_rmax <= rmax_in;
            r_r    <= '0;
            r_dy   <= '0;
        end else if (i_cmd.adv) begin
            if (r_dy == dy_end) begin
                r_r  <= rad_inc;
                r_dy <= -$signed({1'b0, rad_inc});
            end else begin
                r_dy <= r_dy + (RW + 1)'(1);
            end
        end
        if (i_cmd.row) begin
            r_chunk <= chunk_lo;
        end else if (i_cmd.scan && !hit) begin
            r_chunk <= r_chunk + CHW'(1);
        end
    end

    // pending result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ok <= 1'b1;
            r_fx <= '0;
            r_fy <= '0;
        end else if (i_cmd.disp_miss || i_cmd.miss) begin
            r_ok <= 1'b0;
        end else if (i_cmd.upd_cell && r_req == REQ_READ) begin
            r_ok <= cell_bit;
        end else if (i_cmd.scan && hit) begin
            r_ok <= 1'b1;
            r_fx <= 8'(hit_x);
            r_fy <= 8'(y_s);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.ok             <= r_ok;
            r_out.found_x        <= r_fx;
            r_out.found_y        <= r_fy;
            r_out.walkable_count <= (r_req == REQ_COUNT) ? CNT_OUT_W'(r_cnt) : '0;
            r_out.revision       <= r_rev;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

[rtl/occupancy_bitmap_nearest_free_top.sv]
// top level of the walkability map with nearest walkable cell search
//
//  channel   direction  handshake                  payload
//  request   in         i_in_valid / o_in_ready    i_in_data  (t_in)
//  result    out        o_out_valid / i_out_ready  o_out_data (t_out)
//
// a cell read or write in the grid runs dispatch, row read and update; others dispatch only
// search reads and scans each ring row inside the grid, skips rows outside it and
//   scans a top or bottom row one 32-cell chunk at a time via the single row port of the map
// reset leaves every cell walkable at once through per-row valid bits, revision zero
// a result waits in the output register under stall; the next request is taken meanwhile
module occupancy_bitmap_nearest_free_top
    import obnf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_ready
);

    t_cmd cmd;
    t_sts sts;

    obnf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    obnf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

endmodule
